FILE: src/bdpc_pkg.sv
// ----------------------------------------------------------------------------
// bdpc_pkg
// Shared types and constants for the button debounce and press classifier.
// ----------------------------------------------------------------------------
package bdpc_pkg;

    localparam int PinCount = 5;

    // Register indexes on the configuration port (byte address = 4 * index)
    localparam logic [1:0] REG_ACTIVE_LEVEL     = 2'd0;
    localparam logic [1:0] REG_LONG_PRESS_TICKS = 2'd1;
    localparam logic [1:0] REG_DEBOUNCE_TICKS   = 2'd2;

    // Press kinds
    localparam logic [1:0] KIND_SHORT         = 2'd0;
    localparam logic [1:0] KIND_LONG          = 2'd1;
    localparam logic [1:0] KIND_LONG_RELEASED = 2'd2;

    // Reset values
    localparam logic        RST_ACTIVE_LEVEL     = 1'b0;
    localparam logic [15:0] RST_LONG_PRESS_TICKS = 16'd1000;
    localparam logic [7:0]  RST_DEBOUNCE_TICKS   = 8'd40;
    localparam logic [PinCount-1:0] RST_PREV_LEVELS = '1;

    typedef struct packed {
        logic        active_level;
        logic [15:0] long_press_ticks;
        logic [7:0]  debounce_ticks;
    } t_cfg;

    typedef struct packed {
        logic [2:0] button_index;
        logic [1:0] press_kind;
    } t_event;

endpackage

FILE: src/bdpc_if.sv
// ----------------------------------------------------------------------------
// bdpc_if
// Valid/ready channels for pin samples and classified press events.
// ----------------------------------------------------------------------------
interface bdpc_pins_if;
    logic       valid;
    logic       ready;
    logic [4:0] pin_levels;

    modport source (output valid, output pin_levels, input ready);
    modport sink   (input valid, input pin_levels, output ready);
endinterface

interface bdpc_event_if;
    logic       valid;
    logic       ready;
    logic [2:0] button_index;
    logic [1:0] press_kind;

    modport source (output valid, output button_index, output press_kind, input ready);
    modport sink   (input valid, input button_index, input press_kind, output ready);
endinterface

FILE: src/bdpc_apb_regs.sv
// ----------------------------------------------------------------------------
// bdpc_apb_regs
// APB-style register file holding the classifier configuration.
// ----------------------------------------------------------------------------
module bdpc_apb_regs
    import bdpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg       r_cfg;
    logic       w_wr;
    logic [1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[3:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_level     <= RST_ACTIVE_LEVEL;
            r_cfg.long_press_ticks <= RST_LONG_PRESS_TICKS;
            r_cfg.debounce_ticks   <= RST_DEBOUNCE_TICKS;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_ACTIVE_LEVEL:     r_cfg.active_level     <= pwdata[0];
                REG_LONG_PRESS_TICKS: r_cfg.long_press_ticks <= pwdata[15:0];
                REG_DEBOUNCE_TICKS:   r_cfg.debounce_ticks   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_ACTIVE_LEVEL:     prdata = {31'd0, r_cfg.active_level};
            REG_LONG_PRESS_TICKS: prdata = {16'd0, r_cfg.long_press_ticks};
            REG_DEBOUNCE_TICKS:   prdata = {24'd0, r_cfg.debounce_ticks};
            default:              prdata = 32'd0;
        endcase
    end

endmodule

FILE: src/bdpc_core.sv
// ----------------------------------------------------------------------------
// bdpc_core
// Input register, edge detect, priority pick and press state machine.
// ----------------------------------------------------------------------------
module bdpc_core
    import bdpc_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    input  logic          i_in_valid,
    input  logic [4:0]    i_in_levels,
    output logic          o_in_ready,
    input  logic          i_res_room,
    output logic          o_res_valid,
    output t_event        o_res
);

    typedef enum logic [1:0] {PH_IDLE, PH_BOUNCE, PH_ACTIVE, PH_LONG} t_phase;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_chosen, n_chosen;
    logic [4:0]  r_prev;
    logic [15:0] r_tick, n_tick;
    logic        r_in_valid;
    logic [4:0]  r_in_levels;

    logic        w_proc;
    logic [4:0]  w_edges;
    logic        w_any;
    logic [2:0]  w_first;
    logic        w_level;
    logic        w_released;
    logic [15:0] w_tick_inc;
    logic [7:0]  w_limit;
    logic        w_emit;
    logic [1:0]  w_kind;

    assign w_proc     = r_in_valid & i_res_room;
    assign o_in_ready = !r_in_valid | i_res_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_levels <= i_in_levels;
        end
    end

    always_comb begin
        w_edges = r_in_levels ^ r_prev;
        w_any   = |w_edges;
        w_first = 3'(PinCount);
        for (int i = PinCount - 1; i >= 0; i--) begin
            if (w_edges[i]) begin
                w_first = 3'(i);
            end
        end
        case (r_chosen)
            3'd0:    w_level = r_in_levels[0];
            3'd1:    w_level = r_in_levels[1];
            3'd2:    w_level = r_in_levels[2];
            3'd3:    w_level = r_in_levels[3];
            3'd4:    w_level = r_in_levels[4];
            default: w_level = 1'b0;
        endcase
        w_released = w_any && (w_first == r_chosen) && (w_level != i_cfg.active_level);
        w_tick_inc = (r_tick == 16'hFFFF) ? r_tick : r_tick + 16'd1;
        w_limit    = (i_cfg.debounce_ticks == 8'd0) ? 8'd1 : i_cfg.debounce_ticks;
    end

    always_comb begin
        n_phase  = r_phase;
        n_chosen = r_chosen;
        n_tick   = r_tick;
        w_emit   = 1'b0;
        w_kind   = KIND_SHORT;
        unique case (r_phase)
            PH_IDLE: begin
                if (w_any) begin
                    n_chosen = w_first;
                    n_tick   = 16'd0;
                    n_phase  = PH_BOUNCE;
                end
            end
            PH_BOUNCE: begin
                n_tick = w_tick_inc;
                if (w_tick_inc >= {8'd0, w_limit}) begin
                    n_tick  = 16'd0;
                    n_phase = (w_level == i_cfg.active_level) ? PH_ACTIVE : PH_IDLE;
                end
            end
            PH_ACTIVE: begin
                if (w_any) begin
                    n_tick = 16'd0;
                    if (w_released) begin
                        w_emit  = 1'b1;
                        w_kind  = KIND_SHORT;
                        n_phase = PH_IDLE;
                    end
                end else begin
                    n_tick = w_tick_inc;
                    if (i_cfg.long_press_ticks != 16'd0 &&
                        w_tick_inc >= i_cfg.long_press_ticks) begin
                        w_emit  = 1'b1;
                        w_kind  = KIND_LONG;
                        n_tick  = 16'd0;
                        n_phase = PH_LONG;
                    end
                end
            end
            PH_LONG: begin
                if (w_released) begin
                    w_emit  = 1'b1;
                    w_kind  = KIND_LONG_RELEASED;
                    n_tick  = 16'd0;
                    n_phase = PH_IDLE;
                end
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_chosen <= 3'd0;
            r_prev   <= RST_PREV_LEVELS;
            r_tick   <= 16'd0;
        end else if (w_proc) begin
            r_phase  <= n_phase;
            r_chosen <= n_chosen;
            r_prev   <= r_in_levels;
            r_tick   <= n_tick;
        end
    end

    assign o_res_valid       = w_proc & w_emit;
    assign o_res.button_index = r_chosen;
    assign o_res.press_kind   = w_kind;

`ifndef ASSERT_OFF
    a_emit_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (r_phase == PH_ACTIVE || r_phase == PH_LONG))
        else $error("event raised outside active or long phase");

    a_chosen_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IDLE) |-> (r_chosen < 3'(PinCount)))
        else $error("selected button out of range");

    a_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> ((r_phase == PH_IDLE || r_phase == PH_LONG) && r_tick == 16'd0))
        else $error("state not settled after event");
`endif

endmodule

FILE: src/bdpc_out_reg.sv
// ----------------------------------------------------------------------------
// bdpc_out_reg
// Result register driving the event channel.
// ----------------------------------------------------------------------------
module bdpc_out_reg
    import bdpc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_res_valid,
    input  t_event  i_res,
    output logic    o_res_room,
    bdpc_event_if.source o_evt
);

    logic   r_valid;
    t_event r_evt;

    assign o_res_room = !r_valid | o_evt.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_res_room) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_res_room && i_res_valid) begin
            r_evt <= i_res;
        end
    end

    assign o_evt.valid        = r_valid;
    assign o_evt.button_index = r_evt.button_index;
    assign o_evt.press_kind   = r_evt.press_kind;

endmodule

FILE: src/button_debounce_press_classifier_unit.sv
// ----------------------------------------------------------------------------
// button_debounce_press_classifier_unit
// Debounces five joystick buttons and reports short, long and long-released
// presses.
// ----------------------------------------------------------------------------
// Each transaction on the input channel is one millisecond tick carrying the
// sampled levels of the five pins (bit0 up, bit1 down, bit2 left, bit3 right,
// bit4 center). The unit takes one tick per clock cycle while the result
// register has room; a tick is held in the input register, the single-pass
// press state machine classifies it, and any resulting event is registered
// in the result register. A tick produces at most one event. Back-pressure
// on the event channel stalls the input channel only while the result
// register is full.
// Configuration is through the APB-style port: active level at 0x0, long
// press timeout at 0x4 (zero disables long press), debounce wait at 0x8
// (zero behaves as one tick). Write registers only while the unit is idle.
// No clearing pass is needed after reset.
module button_debounce_press_classifier_unit
    import bdpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    bdpc_pins_if.sink   i_pins,
    bdpc_event_if.source o_evt,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg   w_cfg;
    logic   w_res_valid;
    t_event w_res;
    logic   w_res_room;

    // Hold configuration
    bdpc_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Register the tick, detect edges and advance the press state machine
    bdpc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_valid  (i_pins.valid),
        .i_in_levels (i_pins.pin_levels),
        .o_in_ready  (i_pins.ready),
        .i_res_room  (w_res_room),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // Hold the event until the sink takes it
    bdpc_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (w_res_valid),
        .i_res       (w_res),
        .o_res_room  (w_res_room),
        .o_evt       (o_evt)
    );

endmodule
